### rtl/dwc_pkg.sv
package dwc_pkg;

  localparam int INDEX_BITS_DEF = 8;
  localparam int WORD_BITS_DEF  = 80;
  localparam int IN_WORD_BITS   = 80;
  localparam int LOW_BITS       = 64;
  localparam int CODE_BITS      = 8;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [1:0] {
    OP_NOP     = 2'b00,
    OP_COMP    = 2'b01,
    OP_DECOMP  = 2'b10,
    OP_INVALID = 2'b11
  } op_t;

  typedef enum logic [1:0] {
    RESP_IDLE   = 2'b00,
    RESP_DECOMP = 2'b01,
    RESP_COMP   = 2'b10,
    RESP_ERROR  = 2'b11
  } resp_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_ctrl_t;

endpackage

### rtl/dictionary_word_compressor_top.sv
// Path: no-op, error and out-of-range decompress beats go straight to the output register;
// a decompress reads the dictionary RAM and answers from ST_DEC, and a compress scans the
// entries in ST_SCAN (one dictionary RAM read per cycle) until a hit or a miss.
// Throughput: one beat per cycle for no-op/error while out_ready is high; no new beat is
// taken until a decompress or compress is answered; a 2-deep queue decouples input.
// Reset clears the queue, entry count, held code/word and response; no RAM clearing pass.
module dictionary_word_compressor_top #(
  parameter int INDEX_BITS = dwc_pkg::INDEX_BITS_DEF,
  parameter int WORD_BITS  = dwc_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [dwc_pkg::LOW_BITS-1:0]  in_word_low,
  input  logic [dwc_pkg::IN_WORD_BITS-dwc_pkg::LOW_BITS-1:0] in_word_high,
  input  logic [dwc_pkg::CODE_BITS-1:0] in_code_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_response,
  output logic [dwc_pkg::CODE_BITS-1:0] out_code_out,
  output logic [dwc_pkg::LOW_BITS-1:0]  out_word_out_low,
  output logic [dwc_pkg::IN_WORD_BITS-dwc_pkg::LOW_BITS-1:0] out_word_out_high
);

  dwc_pkg::q_ctrl_t              q_ctrl;
  logic                          q_ready;
  logic [WORD_BITS-1:0]          q_word;
  logic [dwc_pkg::CODE_BITS-1:0] q_code;

  dwc_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_word_low  (in_word_low),
    .in_word_high (in_word_high),
    .in_code_in   (in_code_in),
    .q_ctrl       (q_ctrl),
    .q_ready      (q_ready),
    .q_word       (q_word),
    .q_code       (q_code)
  );

  dwc_back #(
    .INDEX_BITS (INDEX_BITS),
    .WORD_BITS  (WORD_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_ctrl            (q_ctrl),
    .q_ready           (q_ready),
    .q_word            (q_word),
    .q_code            (q_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_response      (out_response),
    .out_code_out      (out_code_out),
    .out_word_out_low  (out_word_out_low),
    .out_word_out_high (out_word_out_high)
  );

endmodule

### rtl/dwc_ram.sv
module dwc_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/dwc_front.sv
module dwc_front #(
  parameter int WORD_BITS = dwc_pkg::WORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_opcode,
  input  logic [dwc_pkg::LOW_BITS-1:0]       in_word_low,
  input  logic [dwc_pkg::IN_WORD_BITS-dwc_pkg::LOW_BITS-1:0] in_word_high,
  input  logic [dwc_pkg::CODE_BITS-1:0]      in_code_in,
  output dwc_pkg::q_ctrl_t                   q_ctrl,
  input  logic                               q_ready,
  output logic [WORD_BITS-1:0]               q_word,
  output logic [dwc_pkg::CODE_BITS-1:0]      q_code
);

  localparam int PW = $clog2(dwc_pkg::QUEUE_DEPTH);

  logic [WORD_BITS+dwc_pkg::IN_WORD_BITS-1:0] word_ext;
  logic [WORD_BITS-1:0]                       word_in;
  dwc_pkg::op_t                               op_in;

  dwc_pkg::op_t                    op_mem   [dwc_pkg::QUEUE_DEPTH];
  logic [WORD_BITS-1:0]            word_mem [dwc_pkg::QUEUE_DEPTH];
  logic [dwc_pkg::CODE_BITS-1:0]   code_mem [dwc_pkg::QUEUE_DEPTH];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          push, pop;

  assign word_ext = {{WORD_BITS{1'b0}}, in_word_high, in_word_low};
  assign word_in  = word_ext[WORD_BITS-1:0];

  assign op_in = dwc_pkg::op_t'(in_opcode);

  assign in_ready = (cnt_r != (PW+1)'(dwc_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = q_ctrl.valid && q_ready;

  assign q_ctrl.valid = (cnt_r != '0);
  assign q_ctrl.op    = op_mem[rd_ptr_r];
  assign q_word       = word_mem[rd_ptr_r];
  assign q_code       = code_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_mem[wr_ptr_r]   <= op_in;
      word_mem[wr_ptr_r] <= word_in;
      code_mem[wr_ptr_r] <= in_code_in;
    end
  end

endmodule

### rtl/dwc_back.sv
module dwc_back #(
  parameter int INDEX_BITS = dwc_pkg::INDEX_BITS_DEF,
  parameter int WORD_BITS  = dwc_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dwc_pkg::q_ctrl_t              q_ctrl,
  output logic                          q_ready,
  input  logic [WORD_BITS-1:0]          q_word,
  input  logic [dwc_pkg::CODE_BITS-1:0] q_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_response,
  output logic [dwc_pkg::CODE_BITS-1:0] out_code_out,
  output logic [dwc_pkg::LOW_BITS-1:0]  out_word_out_low,
  output logic [dwc_pkg::IN_WORD_BITS-dwc_pkg::LOW_BITS-1:0] out_word_out_high
);

  localparam int IB = INDEX_BITS;
  localparam int CB = dwc_pkg::CODE_BITS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DEC  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [IB-1:0]         count_r, count_nxt;
  logic [IB-1:0]         idx_r, idx_nxt;
  logic [WORD_BITS-1:0]  word_r, word_nxt;
  logic [IB-1:0]         held_code_r, held_code_nxt;
  logic [WORD_BITS-1:0]  held_word_r, held_word_nxt;
  dwc_pkg::resp_t        resp_r, resp_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  ram_we, ram_re;
  logic [IB-1:0]         ram_raddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [WORD_BITS-1:0]  ram_rdata;

  logic                  out_free, full, code_ok;
  logic [IB-1:0]         idx_inc;
  logic [IB+CB-1:0]      code_wide, count_wide;
  logic [IB+CB-1:0]      held_code_ext;
  logic [WORD_BITS+dwc_pkg::IN_WORD_BITS-1:0] held_word_ext;

  dwc_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (2**INDEX_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free   = !out_valid_r || out_ready;
  assign full       = &count_r;
  assign code_wide  = {{IB{1'b0}}, q_code};
  assign count_wide = {{CB{1'b0}}, count_r};
  assign code_ok    = code_wide < count_wide;
  assign idx_inc    = idx_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    word_nxt      = word_r;
    held_code_nxt = held_code_r;
    held_word_nxt = held_word_r;
    resp_nxt      = resp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_ready       = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = idx_inc;
    ram_wdata     = word_r;
    case (state_r)
      ST_IDLE: begin
        if (q_ctrl.valid && out_free) begin
          q_ready  = 1'b1;
          word_nxt = q_word;
          if (full) begin
            resp_nxt      = dwc_pkg::RESP_ERROR;
            out_valid_nxt = 1'b1;
          end else begin
            case (q_ctrl.op)
              dwc_pkg::OP_NOP: begin
                resp_nxt      = dwc_pkg::RESP_IDLE;
                out_valid_nxt = 1'b1;
              end
              dwc_pkg::OP_DECOMP: begin
                if (code_ok) begin
                  ram_re    = 1'b1;
                  ram_raddr = code_wide[IB-1:0];
                  state_nxt = ST_DEC;
                end else begin
                  resp_nxt      = dwc_pkg::RESP_ERROR;
                  out_valid_nxt = 1'b1;
                end
              end
              dwc_pkg::OP_COMP: begin
                if (count_r == '0) begin
                  ram_we        = 1'b1;
                  ram_wdata     = q_word;
                  word_nxt      = q_word;
                  held_code_nxt = count_r;
                  count_nxt     = count_r + 1'b1;
                  resp_nxt      = dwc_pkg::RESP_COMP;
                  out_valid_nxt = 1'b1;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = '0;
                  idx_nxt   = '0;
                  state_nxt = ST_SCAN;
                end
              end
              default: begin
                resp_nxt      = dwc_pkg::RESP_ERROR;
                out_valid_nxt = 1'b1;
              end
            endcase
          end
        end
      end
      ST_SCAN: begin
        if (ram_rdata == word_r) begin
          held_code_nxt = idx_r;
          resp_nxt      = dwc_pkg::RESP_COMP;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (idx_inc == count_r) begin
          ram_we        = 1'b1;
          held_code_nxt = count_r;
          count_nxt     = count_r + 1'b1;
          resp_nxt      = dwc_pkg::RESP_COMP;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          ram_re  = 1'b1;
          idx_nxt = idx_inc;
        end
      end
      ST_DEC: begin
        held_word_nxt = ram_rdata;
        resp_nxt      = dwc_pkg::RESP_DECOMP;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      held_code_r <= '0;
      held_word_r <= '0;
      resp_r      <= dwc_pkg::RESP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      held_code_r <= held_code_nxt;
      held_word_r <= held_word_nxt;
      resp_r      <= resp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    word_r <= word_nxt;
  end

  assign held_code_ext     = {{CB{1'b0}}, held_code_r};
  assign held_word_ext     = {{dwc_pkg::IN_WORD_BITS{1'b0}}, held_word_r};
  assign out_valid         = out_valid_r;
  assign out_response      = resp_r;
  assign out_code_out      = held_code_ext[CB-1:0];
  assign out_word_out_low  = held_word_ext[dwc_pkg::LOW_BITS-1:0];
  assign out_word_out_high = held_word_ext[dwc_pkg::IN_WORD_BITS-1:dwc_pkg::LOW_BITS];

endmodule

### tb/sv/tb_dictionary_word_compressor_top.sv
module tb_dictionary_word_compressor_top;
  import dwc_pkg::*;

  localparam int TABLE_SIZE    = 1 << INDEX_BITS_DEF;
  localparam int HIGH_BITS     = IN_WORD_BITS - LOW_BITS;
  localparam int RANDOM_BEATS  = 700;
  localparam int DIRECTED_ROWS = 23;
  localparam int DRAIN_CYCLES  = 300;

  localparam logic [LOW_BITS-1:0]  LOW_ONES  = '1;
  localparam logic [HIGH_BITS-1:0] HIGH_ONES = '1;

  typedef struct packed {
    resp_t                response;
    logic [CODE_BITS-1:0] code;
    logic [HIGH_BITS-1:0] word_high;
    logic [LOW_BITS-1:0]  word_low;
  } reply_t;

  typedef struct packed {
    op_t                  op;
    logic [HIGH_BITS-1:0] word_high;
    logic [LOW_BITS-1:0]  word_low;
    logic [CODE_BITS-1:0] code;
    logic                 typed;
    reply_t               reply;
  } beat_t;

  localparam reply_t NO_REPLY = '0;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_opcode;
  logic [LOW_BITS-1:0]  in_word_low;
  logic [HIGH_BITS-1:0] in_word_high;
  logic [CODE_BITS-1:0] in_code_in;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_response;
  logic [CODE_BITS-1:0] out_code_out;
  logic [LOW_BITS-1:0]  out_word_out_low;
  logic [HIGH_BITS-1:0] out_word_out_high;

  logic [IN_WORD_BITS-1:0] dict_words [TABLE_SIZE];
  int                      entry_count;
  logic [CODE_BITS-1:0]    held_code;
  logic [IN_WORD_BITS-1:0] held_word;

  reply_t pending_replies [$];
  int     fail_count = 0;
  bit     quiet_tail = 1'b0;
  int     in_idle_pct = 20;
  int     beats_sent = 0;
  int     out_stall_pct = 20;
  int     ready_hold = 0;
  int     out_cycles = 0;

  dictionary_word_compressor_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_word_low      (in_word_low),
    .in_word_high     (in_word_high),
    .in_code_in       (in_code_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_response     (out_response),
    .out_code_out     (out_code_out),
    .out_word_out_low (out_word_out_low),
    .out_word_out_high(out_word_out_high)
  );

  always #4 clk = ~clk;

  function automatic reply_t compressor_reply(beat_t b);
    reply_t                  r;
    logic [IN_WORD_BITS-1:0] w;
    int                      hit;
    w = {b.word_high, b.word_low};
    hit = -1;
    r = NO_REPLY;
    r.response = RESP_ERROR;
    if (entry_count < TABLE_SIZE - 1) begin
      case (b.op)
        OP_NOP: r.response = RESP_IDLE;
        OP_DECOMP: begin
          if (b.code < entry_count) begin
            held_word = dict_words[b.code];
            r.response = RESP_DECOMP;
          end
        end
        OP_COMP: begin
          for (int i = 0; i < entry_count; i++) begin
            if (hit < 0 && dict_words[i] == w) hit = i;
          end
          if (hit >= 0) begin
            held_code = hit[CODE_BITS-1:0];
          end else begin
            dict_words[entry_count] = w;
            held_code = entry_count[CODE_BITS-1:0];
            entry_count++;
          end
          r.response = RESP_COMP;
        end
        default: r.response = RESP_ERROR;
      endcase
    end
    r.code      = held_code;
    r.word_high = held_word[IN_WORD_BITS-1:LOW_BITS];
    r.word_low  = held_word[LOW_BITS-1:0];
    return r;
  endfunction

  task automatic push_beat(input beat_t b);
    reply_t model_r;
    int     gap;
    if (beats_sent % 64 == 0) begin
      case ($urandom_range(0, 2))
        0: in_idle_pct = 0;
        1: in_idle_pct = 15;
        default: in_idle_pct = 50;
      endcase
    end
    beats_sent++;
    if (!quiet_tail && $urandom_range(0, 99) < in_idle_pct) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= b.op;
    in_word_low  <= b.word_low;
    in_word_high <= b.word_high;
    in_code_in   <= b.code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_r = compressor_reply(b);
    pending_replies.push_back(b.typed ? b.reply : model_r);
  endtask

  always @(posedge clk) begin
    out_cycles++;
    if (out_cycles % 64 == 0) begin
      case ($urandom_range(0, 2))
        0: out_stall_pct = 0;
        1: out_stall_pct = 10;
        default: out_stall_pct = 40;
      endcase
    end
    if (quiet_tail) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      ready_hold = $urandom_range(1, 13) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected beat: response %0d code %0d", out_response, out_code_out);
        fail_count++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (out_response !== exp_r.response) begin
          $error("response: expected %0d, actual %0d", exp_r.response, out_response);
          fail_count++;
        end
        if (out_code_out !== exp_r.code) begin
          $error("code_out: expected %0d, actual %0d", exp_r.code, out_code_out);
          fail_count++;
        end
        if (out_word_out_low !== exp_r.word_low) begin
          $error("word_out_low: expected %h, actual %h", exp_r.word_low, out_word_out_low);
          fail_count++;
        end
        if (out_word_out_high !== exp_r.word_high) begin
          $error("word_out_high: expected %h, actual %h", exp_r.word_high,
                 out_word_out_high);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    beat_t                   directed_rows [DIRECTED_ROWS];
    beat_t                   b;
    logic [IN_WORD_BITS-1:0] w;
    int                      roll;
    int                      sub;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_opcode    <= OP_NOP;
    in_word_low  <= '0;
    in_word_high <= '0;
    in_code_in   <= '0;
    foreach (dict_words[i]) dict_words[i] = '0;
    entry_count = 0;
    held_code   = '0;
    held_word   = '0;

    directed_rows = '{
      '{OP_NOP,     HIGH_ONES, LOW_ONES, 8'hff, 1'b1, '{RESP_IDLE,  8'd0, 16'h0, 64'h0}},
      '{OP_INVALID, HIGH_ONES, LOW_ONES, 8'hff, 1'b1, '{RESP_ERROR, 8'd0, 16'h0, 64'h0}},
      '{OP_DECOMP,  16'h0,     64'h0,    8'h00, 1'b1, '{RESP_ERROR, 8'd0, 16'h0, 64'h0}},
      '{OP_DECOMP,  16'h0,     64'h0,    8'hff, 1'b1, '{RESP_ERROR, 8'd0, 16'h0, 64'h0}},
      '{OP_COMP,    HIGH_ONES, LOW_ONES, 8'h00, 1'b1, '{RESP_COMP,  8'd0, 16'h0, 64'h0}},
      '{OP_COMP,    HIGH_ONES, LOW_ONES, 8'hff, 1'b1, '{RESP_COMP,  8'd0, 16'h0, 64'h0}},
      '{OP_COMP,    16'h0,     64'h0,    8'h00, 1'b1, '{RESP_COMP,  8'd1, 16'h0, 64'h0}},
      '{OP_COMP,    16'h0,     64'h0,    8'h00, 1'b1, '{RESP_COMP,  8'd1, 16'h0, 64'h0}},
      '{OP_DECOMP,  16'h0,     64'h0,    8'h00, 1'b1,
        '{RESP_DECOMP, 8'd1, HIGH_ONES, LOW_ONES}},
      '{OP_DECOMP,  HIGH_ONES, LOW_ONES, 8'h01, 1'b1, '{RESP_DECOMP, 8'd1, 16'h0, 64'h0}},
      '{OP_DECOMP,  16'h0,     64'h0,    8'h02, 1'b1, '{RESP_ERROR, 8'd1, 16'h0, 64'h0}},
      '{OP_COMP,    HIGH_ONES, 64'h0,    8'h00, 1'b1, '{RESP_COMP,  8'd2, 16'h0, 64'h0}},
      '{OP_COMP,    16'h0,     LOW_ONES, 8'h00, 1'b1, '{RESP_COMP,  8'd3, 16'h0, 64'h0}},
      '{OP_COMP,    16'h8000,  64'h1,    8'h55, 1'b0, NO_REPLY},
      '{OP_COMP,    16'h0001,  64'h8000_0000_0000_0000, 8'haa, 1'b0, NO_REPLY},
      '{OP_DECOMP,  16'h0,     64'h0,    8'h05, 1'b0, NO_REPLY},
      '{OP_DECOMP,  16'h0,     64'h0,    8'h02, 1'b0, NO_REPLY},
      '{OP_COMP,    HIGH_ONES, LOW_ONES, 8'h00, 1'b0, NO_REPLY},
      '{OP_COMP,    HIGH_ONES, 64'h0,    8'h00, 1'b0, NO_REPLY},
      '{OP_DECOMP,  16'h0,     64'h0,    8'h06, 1'b0, NO_REPLY},
      '{OP_DECOMP,  16'h0,     64'h0,    8'h03, 1'b0, NO_REPLY},
      '{OP_NOP,     16'h1234,  64'h0123_4567_89ab_cdef, 8'h01, 1'b0, NO_REPLY},
      '{OP_INVALID, 16'h0,     64'h0,    8'h00, 1'b0, NO_REPLY}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) push_beat(directed_rows[i]);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      b           = '0;
      b.word_low  = {$urandom, $urandom};
      b.word_high = HIGH_BITS'($urandom_range(0, 65535));
      b.code      = CODE_BITS'($urandom_range(0, 255));
      roll        = $urandom_range(0, 99);
      if (roll < 42) begin
        b.op = OP_COMP;
        sub  = $urandom_range(0, 3);
        if (entry_count >= TABLE_SIZE - 6) sub = 0;
        if (sub < 2 && entry_count > 0) begin
          w = dict_words[CODE_BITS'($urandom_range(0, entry_count - 1))];
          {b.word_high, b.word_low} = w;
        end else if (sub == 3 && entry_count > 0) begin
          w = dict_words[CODE_BITS'($urandom_range(0, entry_count - 1))];
          w = w ^ ({{(IN_WORD_BITS-1){1'b0}}, 1'b1} << $urandom_range(0, IN_WORD_BITS - 1));
          {b.word_high, b.word_low} = w;
        end
      end else if (roll < 77) begin
        b.op = OP_DECOMP;
        if (entry_count > 0 && $urandom_range(0, 4) != 0)
          b.code = CODE_BITS'($urandom_range(0, entry_count - 1));
      end else if (roll < 90) begin
        b.op = OP_NOP;
      end else begin
        b.op = OP_INVALID;
      end
      push_beat(b);
    end

    quiet_tail = 1'b1;
    while (entry_count < TABLE_SIZE - 1) begin
      b           = '0;
      b.op        = OP_COMP;
      b.word_low  = {$urandom, $urandom};
      b.word_high = HIGH_BITS'($urandom_range(0, 65535));
      b.code      = CODE_BITS'($urandom_range(0, 255));
      push_beat(b);
    end

    for (int n = 0; n < 12; n++) begin
      b           = '0;
      b.op        = op_t'(n % 4);
      b.word_low  = {$urandom, $urandom};
      b.word_high = HIGH_BITS'($urandom_range(0, 65535));
      b.code      = (n < 4) ? 8'd0 : CODE_BITS'($urandom_range(0, 255));
      if (n == 5) {b.word_high, b.word_low} = dict_words[0];
      push_beat(b);
    end
    in_valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
